// ===== hdl/variable_length_instruction_decoder_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the instruction decoder
// Shared forms of the concurrent checks used in the RTL.
// ---------------------------------------------------------------------------
`ifndef VARIABLE_LENGTH_INSTRUCTION_DECODER_CORE_MACROS_SVH
`define VARIABLE_LENGTH_INSTRUCTION_DECODER_CORE_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define VLID_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define VLID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/vlid_pkg.sv =====
// ---------------------------------------------------------------------------
// Instruction decoder package
// Operand kinds, opcode codes, register indexes and the decoded record type.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vlid_pkg;

	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_REG  = 2'd1;
	localparam logic [1:0] KIND_IMM  = 2'd2;
	localparam logic [1:0] KIND_MEM  = 2'd3;

	localparam logic [4:0] OPC_RSV_A = 5'h09;
	localparam logic [4:0] OPC_RSV_B = 5'h0A;
	localparam logic [4:0] OPC_STOP  = 5'h0F;

	localparam logic [1:0] REG_CODE_BASE    = 2'd0;
	localparam logic [1:0] REG_ENTRY_ADDR   = 2'd1;
	localparam logic [1:0] REG_ENTRY_ENABLE = 2'd2;

	localparam int OPND_BYTES = 6;

	typedef struct packed {
		logic [15:0] start_address;
		logic [2:0]  length;
		logic [4:0]  opcode;
		logic        opcode_known;
		logic [1:0]  a_kind;
		logic [7:0]  a_reg;
		logic [15:0] a_value;
		logic [1:0]  b_kind;
		logic [7:0]  b_reg;
		logic [15:0] b_value;
		logic        at_entry;
		logic        is_stop;
	} record_t;

endpackage

`default_nettype wire

// ===== hdl/variable_length_instruction_decoder_core.sv =====
// A record's last code byte passes the input register and then the result register before the record is valid.
// Throughput: one code byte per cycle, set by the single decode pass between the
// input register and the result register; a full result register stalls input only
// while it is not taken.
// Reset clears the byte counter, the stop flag, both valid flags and the
// configuration registers; the address counter restarts at zero.
// ---------------------------------------------------------------------------
// Variable-length instruction decoder core
// Gathers code bytes into instructions and emits one decoded record for each, up to and including a STOP.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "variable_length_instruction_decoder_core_macros.svh"

module variable_length_instruction_decoder_core
	import vlid_pkg::*;
#(
	parameter int ADDRESS_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  code_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [15:0] start_address,
	output logic      [2:0]  length,
	output logic      [4:0]  opcode,
	output logic             opcode_known,
	output logic      [1:0]  a_kind,
	output logic      [7:0]  a_reg,
	output logic      [15:0] a_value,
	output logic      [1:0]  b_kind,
	output logic      [7:0]  b_reg,
	output logic      [15:0] b_value,
	output logic             at_entry,
	output logic             is_stop
);

	logic [15:0] code_base_q;
	logic [15:0] entry_address_q;
	logic        entry_enable_q;

	logic [ADDRESS_BITS-1:0] byte_address_q;
	logic [ADDRESS_BITS-1:0] instr_start_q;
	logic [7:0]              first_byte_q;
	logic [2:0]              count_q;
	logic                    stopped_q;
	logic [7:0]              opnd_q [OPND_BYTES];

	logic        valid_s1;
	logic [7:0]  byte_s1;

	record_t     rec_q;
	logic        rec_valid_q;

	logic                    advance;
	logic                    process;
	logic                    done;
	logic [7:0]              fb;
	logic [1:0]              bk;
	logic [1:0]              ak;
	logic [2:0]              len;
	logic [2:0]              wr_idx;
	logic [ADDRESS_BITS-1:0] start_cur;
	logic [7:0]              full [OPND_BYTES];
	logic [2:0]              a_pos;
	logic [2:0]              a_pos1;
	logic [2:0]              a_pos2;
	logic [31:0]             start_wide;
	record_t                 rec_d;
	logic                    cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		case (paddr[3:2])
			REG_CODE_BASE:    prdata = {16'd0, code_base_q};
			REG_ENTRY_ADDR:   prdata = {16'd0, entry_address_q};
			REG_ENTRY_ENABLE: prdata = {31'd0, entry_enable_q};
			default:          prdata = 32'd0;
		endcase
	end

	assign advance  = !rec_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign process  = valid_s1 && advance && !stopped_q;

	always_comb begin
		fb        = (count_q == 3'd0) ? byte_s1 : first_byte_q;
		start_cur = (count_q == 3'd0) ? byte_address_q : instr_start_q;
		bk        = fb[7:6];
		ak        = fb[5:4];
		len       = 3'd1 + {1'b0, bk} + {1'b0, ak};
		done      = (count_q + 3'd1) == len;
		wr_idx    = count_q - 3'd1;
		for (int k = 0; k < OPND_BYTES; k++) begin
			full[k] = (count_q != 3'd0 && wr_idx == 3'(k)) ? byte_s1 : opnd_q[k];
		end
		a_pos  = {1'b0, bk};
		a_pos1 = a_pos + 3'd1;
		a_pos2 = a_pos + 3'd2;
		start_wide = 32'(start_cur);

		rec_d               = '0;
		rec_d.start_address = start_wide[15:0];
		rec_d.length        = len;
		rec_d.opcode        = fb[4:0];
		rec_d.opcode_known  = !(fb[4:0] inside {OPC_RSV_A, OPC_RSV_B});
		rec_d.a_kind        = ak;
		rec_d.b_kind        = bk;
		rec_d.at_entry      = entry_enable_q && (start_wide == {16'd0, entry_address_q});
		rec_d.is_stop       = fb[4:0] == OPC_STOP;

		case (bk)
			KIND_REG: begin
				rec_d.b_reg = full[0];
			end
			KIND_IMM: begin
				rec_d.b_value = {full[0], full[1]};
			end
			KIND_MEM: begin
				rec_d.b_reg   = full[0];
				rec_d.b_value = {full[1], full[2]};
			end
			default: begin
			end
		endcase

		case (ak)
			KIND_REG: begin
				rec_d.a_reg = full[a_pos];
			end
			KIND_IMM: begin
				rec_d.a_value = {full[a_pos], full[a_pos1]};
			end
			KIND_MEM: begin
				rec_d.a_reg   = full[a_pos];
				rec_d.a_value = {full[a_pos1], full[a_pos2]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_base_q     <= '0;
			entry_address_q <= '0;
			entry_enable_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_CODE_BASE:    code_base_q     <= pwdata[15:0];
				REG_ENTRY_ADDR:   entry_address_q <= pwdata[15:0];
				REG_ENTRY_ENABLE: entry_enable_q  <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= code_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_address_q <= '0;
			instr_start_q  <= '0;
			first_byte_q   <= '0;
			count_q        <= '0;
			stopped_q      <= 1'b0;
		end else if (cfg_wr && paddr[3:2] == REG_CODE_BASE) begin
			byte_address_q <= ADDRESS_BITS'(pwdata[15:0]);
		end else if (process) begin
			byte_address_q <= byte_address_q + ADDRESS_BITS'(1);
			if (done) begin
				count_q <= '0;
				if (rec_d.is_stop) begin
					stopped_q <= 1'b1;
				end
			end else begin
				count_q <= count_q + 3'd1;
				if (count_q == 3'd0) begin
					first_byte_q  <= byte_s1;
					instr_start_q <= byte_address_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (process && !done && count_q != 3'd0) begin
			opnd_q[wr_idx] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (process && done) begin
			rec_valid_q <= 1'b1;
		end else if (out_ready) begin
			rec_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process && done) begin
			rec_q <= rec_d;
		end
	end

	assign out_valid     = rec_valid_q;
	assign start_address = rec_q.start_address;
	assign length        = rec_q.length;
	assign opcode        = rec_q.opcode;
	assign opcode_known  = rec_q.opcode_known;
	assign a_kind        = rec_q.a_kind;
	assign a_reg         = rec_q.a_reg;
	assign a_value       = rec_q.a_value;
	assign b_kind        = rec_q.b_kind;
	assign b_reg         = rec_q.b_reg;
	assign b_value       = rec_q.b_value;
	assign at_entry      = rec_q.at_entry;
	assign is_stop       = rec_q.is_stop;

	`VLID_ASSERT_SAME(a_len_kinds, clk, arst_n, out_valid,
		(length == 3'd1 + {1'b0, b_kind} + {1'b0, a_kind}), "Record length disagrees with kinds.")
	`VLID_ASSERT_SAME(a_stop_flag, clk, arst_n, out_valid && is_stop, stopped_q,
		"A stop record is shown but the decoder is not stopped.")
	`VLID_ASSERT_NEXT(a_stop_sticky, clk, arst_n, stopped_q, stopped_q,
		"The stop flag cleared without reset.")
	`VLID_ASSERT_SAME(a_ready_free, clk, arst_n, !out_valid, in_ready,
		"Input stalled while the result register is empty.")

endmodule

`default_nettype wire

// ===== test/variable_length_instruction_decoder_core_test.sv =====
// ---------------------------------------------------------------------------
// Instruction decoder core testbench
// Streams code bytes into the decoder through its valid/ready input and keeps
// its own decoder of the byte stream. Each record that the core hands out is
// checked field by field against the oldest predicted record. The run goes
// through several base and entry settings, including address wrap, entry
// marking, unassigned opcodes, a base change mid-instruction and STOP at the
// end. Both handshakes are throttled at random, with one long output stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module variable_length_instruction_decoder_core_test;
	import vlid_pkg::*;

	typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 6;
	localparam int STALL_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int REPORT_LIMIT = 10;
	localparam int PHASE_BYTES = 340;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  code_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] start_address;
	logic [2:0]  length;
	logic [4:0]  opcode;
	logic        opcode_known;
	logic [1:0]  a_kind;
	logic [7:0]  a_reg;
	logic [15:0] a_value;
	logic [1:0]  b_kind;
	logic [7:0]  b_reg;
	logic [15:0] b_value;
	logic        at_entry;
	logic        is_stop;

	variable_length_instruction_decoder_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.code_byte(code_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.start_address(start_address),
		.length(length),
		.opcode(opcode),
		.opcode_known(opcode_known),
		.a_kind(a_kind),
		.a_reg(a_reg),
		.a_value(a_value),
		.b_kind(b_kind),
		.b_reg(b_reg),
		.b_value(b_value),
		.at_entry(at_entry),
		.is_stop(is_stop)
	);

	logic [7:0] code_stream[$];
	logic [7:0] instr_buf[$];
	logic [7:0] carry_bytes[$];
	record_t    records_due[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit stall_phase = 1'b0;
	int mismatch_count = 0;

	logic [15:0] cfg_code_base = '0;
	logic [15:0] cfg_entry_addr = '0;
	logic        cfg_entry_en = 1'b0;

	logic [15:0] dec_byte_addr = '0;
	logic [15:0] dec_start = '0;
	logic [7:0]  dec_first = '0;
	logic [2:0]  dec_index = '0;
	logic [47:0] dec_operands = '0;
	logic        dec_stopped = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] make_first(input logic [1:0] bk, input logic [1:0] ak,
			input logic [4:0] opc);
		return {bk, 6'b0} | {2'b0, ak, 4'b0} | {3'b0, opc};
	endfunction

	function automatic void operand_fields(input logic [1:0] kind, input int pos, input int n,
			output logic [7:0] reg_byte, output logic [15:0] value);
		logic [7:0] b[0:5];
		for (int k = 0; k < 6; k++)
			b[k] = (k < n) ? dec_operands[(n - 1 - k) * 8 +: 8] : 8'h00;
		reg_byte = '0;
		value = '0;
		case (kind)
			KIND_REG: begin
				reg_byte = b[pos];
			end
			KIND_IMM: begin
				value = {b[pos], b[pos + 1]};
			end
			KIND_MEM: begin
				reg_byte = b[pos];
				value = {b[pos + 1], b[pos + 2]};
			end
			default: begin
			end
		endcase
	endfunction

	task automatic decode_byte(input logic [7:0] b);
		logic [1:0] bk;
		logic [1:0] ak;
		int len;
		int n;
		record_t rec;
		if (dec_stopped)
			return;
		if (dec_index == 0) begin
			dec_first = b;
			dec_start = dec_byte_addr;
			dec_operands = '0;
		end else begin
			dec_operands = {dec_operands[39:0], b};
		end
		dec_byte_addr = dec_byte_addr + 16'd1;
		dec_index = dec_index + 3'd1;
		bk = dec_first[7:6];
		ak = dec_first[5:4];
		len = 1 + int'(bk) + int'(ak);
		if (int'(dec_index) < len)
			return;
		n = len - 1;
		rec = '0;
		rec.start_address = dec_start;
		rec.length = len[2:0];
		rec.opcode = dec_first[4:0];
		rec.opcode_known = !(rec.opcode == OPC_RSV_A || rec.opcode == OPC_RSV_B);
		rec.a_kind = ak;
		rec.b_kind = bk;
		operand_fields(bk, 0, n, rec.b_reg, rec.b_value);
		operand_fields(ak, int'(bk), n, rec.a_reg, rec.a_value);
		rec.at_entry = cfg_entry_en && (dec_start == cfg_entry_addr);
		rec.is_stop = (rec.opcode == OPC_STOP);
		dec_index = '0;
		dec_operands = '0;
		if (rec.is_stop)
			dec_stopped = 1'b1;
		records_due.push_back(rec);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			code_byte <= '0;
		end else begin
			if (in_valid && in_ready)
				decode_byte(code_byte);
			if (!in_valid || in_ready) begin
				if (code_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					code_byte <= code_stream.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_record();
		record_t got;
		record_t want;
		got = '{start_address, length, opcode, opcode_known, a_kind, a_reg, a_value,
			b_kind, b_reg, b_value, at_entry, is_stop};
		if (records_due.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t: unexpected record at %h, opcode %h", $realtime,
					got.start_address, got.opcode);
			return;
		end
		want = records_due.pop_front();
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT) begin
				$display("%0t: record mismatch", $realtime);
				$display("  expected start %h len %0d opc %h known %b",
					want.start_address, want.length, want.opcode, want.opcode_known,
					" a %0d/%h/%h b %0d/%h/%h entry %b stop %b",
					want.a_kind, want.a_reg, want.a_value, want.b_kind, want.b_reg,
					want.b_value, want.at_entry, want.is_stop);
				$display("  actual   start %h len %0d opc %h known %b",
					got.start_address, got.length, got.opcode, got.opcode_known,
					" a %0d/%h/%h b %0d/%h/%h entry %b stop %b",
					got.a_kind, got.a_reg, got.a_value, got.b_kind, got.b_reg,
					got.b_value, got.at_entry, got.is_stop);
			end
		end
	endtask

	int  stall_left;
	bit  stall_done;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			stall_done <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_record();
			if (stall_phase && !stall_done) begin
				stall_done <= 1'b1;
				stall_left <= STALL_CYCLES;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic cfg_write(input logic [1:0] index, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			REG_CODE_BASE: begin
				cfg_code_base = value[15:0];
				dec_byte_addr = value[15:0];
			end
			REG_ENTRY_ADDR: begin
				cfg_entry_addr = value[15:0];
			end
			REG_ENTRY_ENABLE: begin
				cfg_entry_en = value[0];
			end
			default: begin
			end
		endcase
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (code_stream.size() != 0 || in_valid || records_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic build_instr(input logic [7:0] first, input fill_t fill);
		int count;
		logic [7:0] b;
		count = int'(first[7:6]) + int'(first[5:4]);
		instr_buf.delete();
		instr_buf.push_back(first);
		for (int i = 0; i < count; i++) begin
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				default: b = 8'($urandom_range(0, 255));
			endcase
			instr_buf.push_back(b);
		end
	endtask

	task automatic append_instr();
		foreach (instr_buf[i])
			code_stream.push_back(instr_buf[i]);
	endtask

	function automatic logic [7:0] random_first();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b[4:0] == OPC_STOP)
			b[0] = 1'b0;
		return b;
	endfunction

	task automatic configure(input logic [15:0] base, input logic [15:0] entry,
			input logic enable);
		cfg_write(REG_CODE_BASE, {16'h0, base});
		cfg_write(REG_ENTRY_ADDR, {16'h0, entry});
		cfg_write(REG_ENTRY_ENABLE, {31'h0, enable});
	endtask

	task automatic run_phase(input int send_pct, input int recv_pct, input bit leave_partial);
		int queued;
		int cut;
		fill_t fill;
		logic [7:0] first;
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		queued = carry_bytes.size();
		while (carry_bytes.size() != 0)
			code_stream.push_back(carry_bytes.pop_front());
		while (queued < PHASE_BYTES) begin
			case ($urandom_range(0, 9))
				0: fill = FILL_ZERO;
				1: fill = FILL_ONES;
				default: fill = FILL_RANDOM;
			endcase
			build_instr(random_first(), fill);
			append_instr();
			queued += instr_buf.size();
		end
		if (leave_partial) begin
			first = random_first();
			first[7:6] = KIND_MEM;
			build_instr(first, FILL_RANDOM);
			cut = $urandom_range(1, instr_buf.size() - 1);
			foreach (instr_buf[i]) begin
				if (i < cut)
					code_stream.push_back(instr_buf[i]);
				else
					carry_bytes.push_back(instr_buf[i]);
			end
		end
	endtask

	initial begin
		logic [15:0] base;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		configure(16'hFFFE, 16'hFFFF, 1'b1);
		@(negedge clk);
		send_idle_pct = 21;
		recv_idle_pct = 88;
		build_instr(8'h00, FILL_ZERO);
		append_instr();
		build_instr(8'hFF, FILL_ONES);
		append_instr();
		build_instr(make_first(KIND_NONE, KIND_NONE, OPC_RSV_A), FILL_ZERO);
		append_instr();
		build_instr(make_first(KIND_NONE, KIND_NONE, OPC_RSV_B), FILL_ZERO);
		append_instr();
		build_instr(8'hF0, FILL_ZERO);
		append_instr();
		build_instr(make_first(KIND_REG, KIND_REG, 5'h1A), FILL_RANDOM);
		append_instr();
		build_instr(make_first(KIND_IMM, KIND_IMM, 5'h01), FILL_RANDOM);
		append_instr();

		wait_idle();
		configure(16'h0000, 16'(carry_bytes.size()), 1'b1);
		run_phase(21, 88, 1'b1);

		wait_idle();
		configure(16'hFFFF, 16'hFFFF + 16'(carry_bytes.size()), 1'b0);
		run_phase(88, 21, 1'b1);

		wait_idle();
		base = 16'($urandom_range(0, 65535));
		cfg_write(REG_UNUSED, $urandom);
		configure(base, base + 16'(carry_bytes.size()), 1'b1);
		run_phase(88, 21, 1'b1);

		wait_idle();
		base = 16'($urandom_range(0, 65535));
		configure(base, 16'hFFFF, 1'b1);
		stall_phase = 1'b1;
		run_phase(0, 0, 1'b0);
		build_instr(make_first(KIND_MEM, KIND_IMM, OPC_STOP), FILL_RANDOM);
		append_instr();
		repeat (20)
			code_stream.push_back(8'($urandom_range(0, 255)));

		wait_idle();
		if (mismatch_count == 0 && records_due.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
